@@ sv/rsi_pkg.sv @@
// rsi_pkg: widths, carried-data structs and step functions for the ray/sphere core.
// No dependencies; used by rsi_sqrt, rsi_div and ray_sphere_intersect_core.
package rsi_pkg;

  localparam int CW      = 32;   // Q16.16 coordinate
  localparam int DW      = 18;   // Q1.16 unit component
  localparam int RW      = 31;   // radius
  localparam int TQ_W    = 36;   // floored projection (non-negative when live)
  localparam int ROOT_W  = 37;   // sqrt result bits
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int SQ_PER  = 2;    // sqrt steps per stage
  localparam int SQ_STAGES = (ROOT_W + SQ_PER - 1) / SQ_PER;
  localparam int TN_W    = 38;   // near root
  localparam int HP_W    = 41;   // unsaturated hit point
  localparam int DF_W    = 42;   // hit point minus center
  localparam int Q_W     = 16;   // normal fraction bits
  localparam int DIV_PER = 2;    // divide steps per stage
  localparam int DIV_STAGES = Q_W / DIV_PER;
  localparam int DREM_W  = RW + 1;

  localparam logic signed [DW-1:0] ONE_Q16 = DW'(65536);

  typedef struct packed {
    logic                 live;
    logic [2:0][CW-1:0]   org;
    logic [2:0][DW-1:0]   dir;
    logic [2:0][CW-1:0]   ctr;
    logic [RW-1:0]        r;
    logic [CW-1:0]        maxd;
    logic [TQ_W-1:0]      tq;
  } sq_side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_work_t;

  typedef struct packed {
    logic                 live;
    logic [TN_W-1:0]      tn;
    logic [2:0][HP_W-1:0] hitp;
    logic [2:0]           neg;
    logic [2:0]           big;
    logic [RW-1:0]        r;
  } dv_side_t;

  typedef struct packed {
    logic [2:0][DREM_W-1:0] rem;
    logic [2:0][Q_W-1:0]    q;
  } dv_work_t;

  // one restoring square-root digit
  function automatic sq_work_t sqrt_step(sq_work_t w);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sq_work_t o;
    cur   = {w.rem[REM_W-3:0], w.rad[RAD_W-1 -: 2]};
    trial = {1'b0, w.root, 2'b01};
    o.rad = {w.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      o.rem  = cur - trial;
      o.root = {w.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = cur;
      o.root = {w.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring divide bit, all three lanes
  function automatic dv_work_t div_step(dv_work_t w, logic [RW-1:0] r);
    logic [DREM_W-1:0] cur;
    dv_work_t o;
    o = w;
    for (int i = 0; i < 3; i++) begin
      cur = {w.rem[i][DREM_W-2:0], 1'b0};
      if (cur >= {1'b0, r}) begin
        o.rem[i] = cur - {1'b0, r};
        o.q[i]   = {w.q[i][Q_W-2:0], 1'b1};
      end else begin
        o.rem[i] = cur;
        o.q[i]   = {w.q[i][Q_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic [CW-1:0] sat32(logic signed [DF_W-1:0] v);
    if (v > DF_W'(64'sh7FFF_FFFF))
      return 32'h7FFF_FFFF;
    else if (v < -DF_W'(64'sh8000_0000))
      return 32'h8000_0000;
    else
      return v[CW-1:0];
  endfunction

endpackage

@@ sv/rsi_sqrt.sv @@
// rsi_sqrt: pipelined restoring integer square root, SQ_PER digits per stage.
// Carries rsi_pkg::sq_side_t alongside; depends on rsi_pkg.
module rsi_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [rsi_pkg::RAD_W-1:0]    in_rad,
  input  rsi_pkg::sq_side_t            in_side,
  output logic                         out_valid,
  output logic [rsi_pkg::ROOT_W-1:0]   out_root,
  output rsi_pkg::sq_side_t            out_side
);

  logic              vld  [rsi_pkg::SQ_STAGES];
  rsi_pkg::sq_work_t work [rsi_pkg::SQ_STAGES];
  rsi_pkg::sq_side_t side [rsi_pkg::SQ_STAGES];

  for (genvar s = 0; s < rsi_pkg::SQ_STAGES; s++) begin : g_stage
    rsi_pkg::sq_work_t work_in;
    rsi_pkg::sq_work_t work_next;
    logic              vld_in;
    rsi_pkg::sq_side_t side_in;

    if (s == 0) begin : g_head
      assign work_in = '{rem: '0, root: '0, rad: in_rad};
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_body
      assign work_in = work[s-1];
      assign vld_in  = vld[s-1];
      assign side_in = side[s-1];
    end

    always_comb begin
      rsi_pkg::sq_work_t w;
      w = work_in;
      for (int k = 0; k < rsi_pkg::SQ_PER; k++) begin
        if (s * rsi_pkg::SQ_PER + k < rsi_pkg::ROOT_W)
          w = rsi_pkg::sqrt_step(w);
      end
      work_next = w;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_in;
      end
      if (en) begin
        work[s] <= work_next;
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[rsi_pkg::SQ_STAGES-1];
  assign out_root  = work[rsi_pkg::SQ_STAGES-1].root;
  assign out_side  = side[rsi_pkg::SQ_STAGES-1];

endmodule

@@ sv/rsi_div.sv @@
// rsi_div: three-lane pipelined restoring divider, (mag << 16) / r for mag < r.
// Carries rsi_pkg::dv_side_t (which holds r); depends on rsi_pkg.
module rsi_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][rsi_pkg::RW-1:0]         in_mag,
  input  rsi_pkg::dv_side_t                   in_side,
  output logic                                out_valid,
  output logic [2:0][rsi_pkg::Q_W-1:0]        out_q,
  output rsi_pkg::dv_side_t                   out_side
);

  logic              vld  [rsi_pkg::DIV_STAGES];
  rsi_pkg::dv_work_t work [rsi_pkg::DIV_STAGES];
  rsi_pkg::dv_side_t side [rsi_pkg::DIV_STAGES];

  for (genvar s = 0; s < rsi_pkg::DIV_STAGES; s++) begin : g_stage
    rsi_pkg::dv_work_t work_in;
    rsi_pkg::dv_work_t work_next;
    logic              vld_in;
    rsi_pkg::dv_side_t side_in;

    if (s == 0) begin : g_head
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          work_in.rem[i] = {1'b0, in_mag[i]};
          work_in.q[i]   = '0;
        end
      end
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_body
      assign work_in = work[s-1];
      assign vld_in  = vld[s-1];
      assign side_in = side[s-1];
    end

    always_comb begin
      rsi_pkg::dv_work_t w;
      w = work_in;
      for (int k = 0; k < rsi_pkg::DIV_PER; k++)
        w = rsi_pkg::div_step(w, side_in.r);
      work_next = w;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_in;
      end
      if (en) begin
        work[s] <= work_next;
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[rsi_pkg::DIV_STAGES-1];
  assign out_q     = work[rsi_pkg::DIV_STAGES-1].q;
  assign out_side  = side[rsi_pkg::DIV_STAGES-1];

endmodule

@@ sv/ray_sphere_intersect_core.sv @@
// ray_sphere_intersect_core: fixed-point geometric ray/sphere test, fully pipelined.
// Depends on rsi_pkg, rsi_sqrt and rsi_div.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+--------------------------------------------
//   s_      | in  | tvalid / tready  | tdata: ray origin, direction, sphere, max_distance
//   m_      | out | tvalid / tready  | tuser: hit; tdata: distance, hit point, normal
//
// One request enters per cycle unless m_tready stalls. The square-root (SQ_STAGES, 19)
// and divider (DIV_STAGES, 8) digit pipelines work two digits per stage.
// rst (synchronous) clears only the valid bits; payload registers are not reset.
// A stall on m_tready freezes every stage at once; s_tready is high whenever the
// output register is empty or being taken, so a stall holds the input back with it.
module ray_sphere_intersect_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z (32 each), dir_x, dir_y, dir_z (18 each),
  // center_x, center_y, center_z (32 each), radius (31), max_distance (32), 3 pad
  input  logic [311:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit
  output logic         m_tuser,
  // distance, hit_x, hit_y, hit_z (32 each), normal_x, normal_y, normal_z (18 each), 2 pad
  output logic [183:0] m_tdata
);

  localparam int CW = rsi_pkg::CW;
  localparam int DW = rsi_pkg::DW;
  localparam int RW = rsi_pkg::RW;

  logic en;
  assign en       = m_tready | ~m_tvalid;
  assign s_tready = en;

  // ---- input unpack
  logic [CW-1:0] in_org [3];
  logic [DW-1:0] in_dir [3];
  logic [CW-1:0] in_ctr [3];
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign in_org[i] = s_tdata[i*CW +: CW];
    assign in_dir[i] = s_tdata[3*CW + i*DW +: DW];
    assign in_ctr[i] = s_tdata[3*CW + 3*DW + i*CW +: CW];
  end

  // ---- stage 1: dst = center - origin
  logic                   v1;
  logic [2:0][CW-1:0]     org1, ctr1;
  logic [2:0][DW-1:0]     dir1;
  logic signed [CW:0]     dst1 [3];
  logic [RW-1:0]          r1;
  logic [CW-1:0]          maxd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        org1[i] <= in_org[i];
        dir1[i] <= in_dir[i];
        ctr1[i] <= in_ctr[i];
        dst1[i] <= $signed({in_ctr[i][CW-1], in_ctr[i]}) -
                   $signed({in_org[i][CW-1], in_org[i]});
      end
      r1    <= s_tdata[3*CW + 3*DW + 3*CW +: RW];
      maxd1 <= s_tdata[3*CW + 3*DW + 3*CW + RW +: CW];
    end
  end

  // ---- stage 2: projection products and squared distances
  logic                   v2;
  logic [2:0][CW-1:0]     org2, ctr2;
  logic [2:0][DW-1:0]     dir2;
  logic signed [50:0]     p2 [3];
  logic [63:0]            sq2 [3];
  logic [RW-1:0]          r2;
  logic [CW-1:0]          maxd2;
  logic [CW:0]            amag1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      amag1[i] = dst1[i][CW] ? (CW+1)'(-dst1[i]) : dst1[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2[i]  <= dst1[i] * $signed(dir1[i]);
        sq2[i] <= amag1[i][CW-1:0] * amag1[i][CW-1:0];
      end
      org2 <= org1; ctr2 <= ctr1; dir2 <= dir1; r2 <= r1; maxd2 <= maxd1;
    end
  end

  // ---- stage 3: dot product and |dst|^2
  logic                   v3;
  logic [2:0][CW-1:0]     org3, ctr3;
  logic [2:0][DW-1:0]     dir3;
  logic signed [52:0]     tsum3;
  logic [65:0]            dd3;
  logic [RW-1:0]          r3;
  logic [CW-1:0]          maxd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      tsum3 <= 53'(p2[0]) + 53'(p2[1]) + 53'(p2[2]);
      dd3   <= 66'(sq2[0]) + 66'(sq2[1]) + 66'(sq2[2]);
      org3 <= org2; ctr3 <= ctr2; dir3 <= dir2; r3 <= r2; maxd3 <= maxd2;
    end
  end

  // ---- stage 4: floor to Q16.16, square t and r
  logic                        v4, tpos4;
  logic [2:0][CW-1:0]          org4, ctr4;
  logic [2:0][DW-1:0]          dir4;
  logic [rsi_pkg::TQ_W-1:0]    tq4;
  logic [71:0]                 tq2_4;
  logic [61:0]                 rr4;
  logic [65:0]                 dd4;
  logic [RW-1:0]               r4;
  logic [CW-1:0]               maxd4;
  logic [rsi_pkg::TQ_W-1:0]    tq3;

  assign tq3 = tsum3[16 +: rsi_pkg::TQ_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      tpos4 <= (tsum3 > 53'sd0);
      tq4   <= tq3;
      tq2_4 <= tq3 * tq3;
      rr4   <= r3 * r3;
      dd4   <= dd3;
      org4 <= org3; ctr4 <= ctr3; dir4 <= dir3; r4 <= r3; maxd4 <= maxd3;
    end
  end

  // ---- stage 5: discriminant
  logic                   v5;
  logic signed [74:0]     d5;
  rsi_pkg::sq_side_t      side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      d5 <= $signed({3'b0, tq2_4}) + $signed({13'b0, rr4}) - $signed({9'b0, dd4});
      side5.live <= tpos4;
      side5.org  <= org4;
      side5.dir  <= dir4;
      side5.ctr  <= ctr4;
      side5.r    <= r4;
      side5.maxd <= maxd4;
      side5.tq   <= tq4;
    end
  end

  rsi_pkg::sq_side_t sq_in_side;
  always_comb begin
    sq_in_side      = side5;
    sq_in_side.live = side5.live & ~d5[74] & (d5 != 75'sd0);
  end

  // ---- square root pipeline
  logic                         sq_valid;
  logic [rsi_pkg::ROOT_W-1:0]   sq_root;
  rsi_pkg::sq_side_t            sq_side;

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_rad    (d5[rsi_pkg::RAD_W-1:0]),
    .in_side   (sq_in_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---- stage 6: near root and distance test
  logic                            v6, live6;
  logic signed [rsi_pkg::TN_W-1:0] tn6;
  logic [2:0][CW-1:0]              org6, ctr6;
  logic [2:0][DW-1:0]              dir6;
  logic [RW-1:0]                   r6;
  logic signed [rsi_pkg::TN_W-1:0] tn_c;

  assign tn_c = $signed({2'b0, sq_side.tq}) - $signed({1'b0, sq_root});

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= sq_valid;
    end
    if (en) begin
      tn6   <= tn_c;
      live6 <= sq_side.live & (tn_c < rsi_pkg::TN_W'($signed(sq_side.maxd)));
      org6 <= sq_side.org; ctr6 <= sq_side.ctr; dir6 <= sq_side.dir; r6 <= sq_side.r;
    end
  end

  // ---- stage 7: tn * dir
  logic                            v7, live7;
  logic signed [rsi_pkg::TN_W-1:0] tn7;
  logic signed [55:0]              prod7 [3];
  logic [2:0][CW-1:0]              org7, ctr7;
  logic [RW-1:0]                   r7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      for (int i = 0; i < 3; i++)
        prod7[i] <= tn6 * $signed(dir6[i]);
      tn7 <= tn6; live7 <= live6; org7 <= org6; ctr7 <= ctr6; r7 <= r6;
    end
  end

  // ---- stage 8: hit point (unsaturated)
  logic                              v8, live8;
  logic signed [rsi_pkg::TN_W-1:0]   tn8;
  logic signed [rsi_pkg::HP_W-1:0]   hitp8 [3];
  logic [2:0][CW-1:0]                ctr8;
  logic [RW-1:0]                     r8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
    if (en) begin
      for (int i = 0; i < 3; i++)
        hitp8[i] <= rsi_pkg::HP_W'($signed(org7[i])) + rsi_pkg::HP_W'(prod7[i] >>> 16);
      tn8 <= tn7; live8 <= live7; ctr8 <= ctr7; r8 <= r7;
    end
  end

  // ---- stage 9: hit - center, sign and magnitude, saturating compare
  logic                     v9;
  logic [2:0][RW-1:0]       mag9;
  rsi_pkg::dv_side_t        side9;
  logic signed [rsi_pkg::DF_W-1:0] diff_c [3];
  logic [rsi_pkg::DF_W-1:0]        mag_c  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = rsi_pkg::DF_W'(hitp8[i]) - rsi_pkg::DF_W'($signed(ctr8[i]));
      mag_c[i]  = diff_c[i][rsi_pkg::DF_W-1] ? rsi_pkg::DF_W'(-diff_c[i]) : diff_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag9[i]          <= mag_c[i][RW-1:0];
        side9.hitp[i]    <= hitp8[i];
        side9.neg[i]     <= diff_c[i][rsi_pkg::DF_W-1];
        side9.big[i]     <= (mag_c[i] >= rsi_pkg::DF_W'(r8));
      end
      side9.live <= live8;
      side9.tn   <= tn8;
      side9.r    <= r8;
    end
  end

  // ---- normal divider pipeline
  logic                              dv_valid;
  logic [2:0][rsi_pkg::Q_W-1:0]      dv_q;
  rsi_pkg::dv_side_t                 dv_side;

  rsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v9),
    .in_mag    (mag9),
    .in_side   (side9),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // ---- output register: saturate, sign the normal, zero on miss
  logic [183:0] tdata_next;

  always_comb begin
    logic signed [DW-1:0] nq;
    tdata_next = '0;
    nq         = '0;
    if (dv_side.live) begin
      tdata_next[0 +: CW] = rsi_pkg::sat32(rsi_pkg::DF_W'($signed(dv_side.tn)));
      for (int i = 0; i < 3; i++) begin
        tdata_next[CW + i*CW +: CW] =
          rsi_pkg::sat32(rsi_pkg::DF_W'($signed(dv_side.hitp[i])));
        nq = dv_side.big[i] ? rsi_pkg::ONE_Q16 : $signed({2'b0, dv_q[i]});
        tdata_next[4*CW + i*DW +: DW] = dv_side.neg[i] ? DW'(-nq) : nq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
    if (en) begin
      m_tuser <= dv_side.live;
      m_tdata <= tdata_next;
    end
  end

endmodule
